/* src/weight_optimizer_update_core_defines.svh */
// Assertion macros shared by the checker.
`ifndef WEIGHT_OPTIMIZER_UPDATE_CORE_DEFINES_SVH
`define WEIGHT_OPTIMIZER_UPDATE_CORE_DEFINES_SVH

// Property checked only while reset is released.
`define WOU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define WOU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/wou_pkg.sv */
package wou_pkg;

    // Fixed formats.
    localparam int FRAC_BITS    = 24;
    localparam int DATA_W       = 32;
    localparam int INDEX_W      = 12;
    localparam int WEIGHT_COUNT = 4096;
    localparam int COEF_W       = 25;
    localparam int MODE_W       = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = 2;

    // Square root and divider sizes.
    localparam int X_W      = DATA_W + FRAC_BITS;
    localparam int ROOT_W   = X_W / 2;
    localparam int SREM_W   = ROOT_W + 4;
    localparam int NUM_W    = DATA_W + FRAC_BITS + 1;
    localparam int QUO_W    = DATA_W;
    localparam int STORE_W  = 3 * DATA_W;

    // Pipeline stage positions.
    localparam int ST_MUL      = 1;
    localparam int ST_IAG      = 2;
    localparam int ST_RAD      = 3;
    localparam int ST_SQ0      = 4;
    localparam int ST_DPREP    = ST_SQ0 + ROOT_W;
    localparam int ST_DV0      = ST_DPREP + 1;
    localparam int ST_GN       = ST_DV0 + QUO_W;
    localparam int ST_T        = ST_GN + 1;
    localparam int ST_DN       = ST_T + 1;
    localparam int ST_WN       = ST_DN + 1;
    localparam int STAGE_COUNT = ST_WN + 1;

    // Operation and mode codes.
    localparam logic       OP_LOAD   = 1'b0;
    localparam logic       OP_APPLY  = 1'b1;
    localparam logic [2:0] MODE_SGD  = 3'd0;
    localparam logic [2:0] MODE_MOM  = 3'd1;
    localparam logic [2:0] MODE_RMS  = 3'd2;
    localparam logic [2:0] MODE_ADA  = 3'd3;
    localparam logic [2:0] MODE_MR   = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MODE   = 3'd0;
    localparam logic [2:0] CFG_L2     = 3'd1;
    localparam logic [2:0] CFG_LR     = 3'd2;
    localparam logic [2:0] CFG_MOMENT = 3'd3;
    localparam logic [2:0] CFG_DECAY  = 3'd4;
    localparam logic [2:0] CFG_SHRINK = 3'd5;

    localparam logic [COEF_W-1:0] LR_RESET     = 25'd167772;
    localparam logic [COEF_W-1:0] MOMENT_RESET = 25'd15099494;
    localparam logic [COEF_W-1:0] DECAY_RESET  = 25'd15099494;
    localparam logic [COEF_W-1:0] SHRINK_RESET = 25'd16777216;

    localparam logic signed [DATA_W:0] ONE_Q = 33'(64'd1 << FRAC_BITS);
    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              l2_on;
        logic [COEF_W-1:0] learn_rate;
        logic [COEF_W-1:0] momentum;
        logic [COEF_W-1:0] rms_decay;
        logic [COEF_W-1:0] shrink;
    } cfg_t;

    typedef struct packed {
        logic                     apply;
        logic [INDEX_W-1:0]       index;
        logic signed [DATA_W-1:0] value;
    } q_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     clip;
    } sat_t;

    typedef struct packed {
        logic                     valid;
        logic                     apply;
        logic                     write;
        logic                     clip;
        logic                     ovf;
        logic [INDEX_W-1:0]       index;
        logic signed [DATA_W-1:0] g;
        logic signed [DATA_W-1:0] w;
        logic signed [DATA_W-1:0] d;
        logic signed [DATA_W-1:0] r;
        logic signed [DATA_W-1:0] base;
        logic signed [DATA_W-1:0] g2;
        logic signed [DATA_W-1:0] ar;
        logic signed [DATA_W-1:0] md;
        logic signed [DATA_W-1:0] lg;
        logic signed [DATA_W-1:0] iag2;
        logic signed [DATA_W-1:0] r3;
        logic signed [DATA_W-1:0] rn;
        logic signed [DATA_W-1:0] gn;
        logic signed [DATA_W-1:0] t;
        logic signed [DATA_W-1:0] dn;
        logic signed [DATA_W-1:0] step;
        logic signed [DATA_W-1:0] wn;
        logic [X_W-1:0]           x;
        logic [SREM_W-1:0]        srem;
        logic [ROOT_W-1:0]        root;
        logic [QUO_W-1:0]         nlo;
        logic [ROOT_W-1:0]        drem;
        logic [QUO_W-1:0]         q;
    } stage_t;

    // Saturate a 33-bit signed value to 32 bits.
    function automatic sat_t sat33(input logic signed [DATA_W:0] v);
        sat_t res;
        res.clip = 1'b0;
        res.val  = v[DATA_W-1:0];
        if (v > 33'(SAT_MAX)) begin
            res.clip = 1'b1;
            res.val  = SAT_MAX;
        end else if (v < 33'(SAT_MIN)) begin
            res.clip = 1'b1;
            res.val  = SAT_MIN;
        end
        return res;
    endfunction

    // Saturating add of two 32-bit signed values.
    function automatic sat_t add_sat(input logic signed [DATA_W-1:0] a,
                                     input logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0] s;
        s = 33'(a) + 33'(b);
        return sat33(s);
    endfunction

    // Fixed-point multiply, rounded half away from zero, saturated.
    function automatic sat_t mulq(input logic signed [DATA_W:0] a,
                                  input logic signed [DATA_W:0] b);
        logic signed [2*DATA_W+1:0] p;
        logic                       neg;
        logic [2*DATA_W+1:0]        mag;
        logic [2*DATA_W+1:0]        rnd;
        sat_t                       res;
        p   = a * b;
        neg = p[2*DATA_W+1];
        mag = neg ? 66'(-p) : 66'(p);
        rnd = (mag + (66'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        res.clip = 1'b0;
        res.val  = neg ? -rnd[DATA_W-1:0] : rnd[DATA_W-1:0];
        if (!neg && rnd > 66'(SAT_MAX)) begin
            res.clip = 1'b1;
            res.val  = SAT_MAX;
        end else if (neg && rnd > (66'(1) << (DATA_W - 1))) begin
            res.clip = 1'b1;
            res.val  = SAT_MIN;
        end
        return res;
    endfunction

    // One minus an unsigned coefficient, as a signed value.
    function automatic logic signed [DATA_W:0] one_minus(input logic [COEF_W-1:0] c);
        return ONE_Q - 33'(c);
    endfunction

endpackage

/* src/wou_front.sv */
module wou_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       operation,
    input  logic [wou_pkg::INDEX_W-1:0] index,
    input  logic signed [wou_pkg::DATA_W-1:0] value,
    output logic                       q_valid,
    output wou_pkg::q_item_t           q_item,
    input  logic                       q_pop
);

    wou_pkg::q_item_t               entry_reg [wou_pkg::QUEUE_DEPTH];
    logic [wou_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [wou_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [wou_pkg::QPTR_W:0]       count_reg;
    logic [wou_pkg::QPTR_W:0]       count_next;
    logic                           push;
    wou_pkg::q_item_t               classified;

    // Classify the incoming item.
    always_comb
    begin
        classified.apply = (operation == wou_pkg::OP_APPLY);
        classified.index = index;
        classified.value = value;
    end

    assign in_stall = (count_reg == (wou_pkg::QPTR_W + 1)'(wou_pkg::QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

/* src/wou_back.sv */
module wou_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  wou_pkg::cfg_t                     cfg,
    input  logic                              q_valid,
    input  wou_pkg::q_item_t                  q_item,
    output logic                              q_pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [wou_pkg::INDEX_W-1:0]       out_index,
    output logic signed [wou_pkg::DATA_W-1:0] weight,
    output logic                              saturated
);

    localparam int NSTG = wou_pkg::STAGE_COUNT;
    localparam int DW   = wou_pkg::DATA_W;
    localparam int RW   = wou_pkg::ROOT_W;
    localparam int QW   = wou_pkg::QUO_W;
    localparam int NW   = wou_pkg::NUM_W;
    localparam int ST_MUL_PREV = wou_pkg::ST_MUL - 1;

    wou_pkg::stage_t st_reg  [NSTG];
    wou_pkg::stage_t st_next [NSTG];

    logic [wou_pkg::STORE_W-1:0] store_reg [wou_pkg::WEIGHT_COUNT];
    logic [wou_pkg::STORE_W-1:0] rd_reg;

    wou_pkg::sat_t lr_im_reg;
    wou_pkg::sat_t lr_m_reg;

    logic                         out_valid_reg;
    logic [wou_pkg::INDEX_W-1:0]  out_index_reg;
    logic signed [DW-1:0]         weight_reg;
    logic                         saturated_reg;

    logic            en;
    logic [NSTG-1:0] match;
    logic            hit;

    logic m_sgd, m_mom, m_rms, m_ada, m_mr, m_known, m_sq, m_decay;
    logic signed [DW:0] lr_c;
    logic signed [DW:0] ia_c;

    // Mode decode; the user must hold the configuration while items are in flight, the block does not enforce it.
    assign m_sgd   = (cfg.mode == wou_pkg::MODE_SGD);
    assign m_mom   = (cfg.mode == wou_pkg::MODE_MOM);
    assign m_rms   = (cfg.mode == wou_pkg::MODE_RMS);
    assign m_ada   = (cfg.mode == wou_pkg::MODE_ADA);
    assign m_mr    = (cfg.mode == wou_pkg::MODE_MR);
    assign m_known = m_sgd || m_mom || m_rms || m_ada || m_mr;
    assign m_sq    = m_rms || m_ada || m_mr;
    assign m_decay = m_rms || m_mr;
    assign lr_c    = (DW + 1)'(cfg.learn_rate);
    assign ia_c    = wou_pkg::one_minus(cfg.rms_decay);

    // Derived coefficients, refreshed every cycle.
    always_ff @(posedge clk)
    begin
        lr_im_reg <= wou_pkg::mulq(lr_c, wou_pkg::one_minus(cfg.momentum));
        lr_m_reg  <= wou_pkg::mulq(lr_c, (DW + 1)'(cfg.momentum));
    end

    // The pipeline advances whenever the output register can take a transfer.
    assign en = !(out_valid_reg && out_stall);

    // An element already in flight blocks issue until it is written back.
    for (genvar k = 0; k < NSTG; k++)
    begin : g_match
        assign match[k] = st_reg[k].valid && (st_reg[k].index == q_item.index);
    end
    assign hit   = |match;
    assign q_pop = en && q_valid && !hit;

    // Issue stage.
    always_comb
    begin
        st_next[0]       = '0;
        st_next[0].valid = q_valid && !hit;
        st_next[0].apply = q_item.apply;
        st_next[0].index = q_item.index;
        st_next[0].g     = q_item.value;
    end

    // Element store: one read at issue, one write at retirement.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_reg <= store_reg[q_item.index];
            if (st_reg[NSTG-1].valid && st_reg[NSTG-1].write)
            begin
                store_reg[st_reg[NSTG-1].index] <=
                    {st_reg[NSTG-1].wn, st_reg[NSTG-1].dn, st_reg[NSTG-1].rn};
            end
        end
    end

    // First multiplies: base, g squared, decayed r, momentum term, plain step.
    always_comb
    begin
        wou_pkg::stage_t s;
        wou_pkg::sat_t   mb, mg2, mar, mmd, mlg;
        logic signed [DW:0] md_c, lg_c;
        s      = st_reg[ST_MUL_PREV];
        s.w    = rd_reg[3*DW-1:2*DW];
        s.d    = rd_reg[2*DW-1:DW];
        s.r    = rd_reg[DW-1:0];
        md_c   = m_mr ? (DW + 1)'(lr_m_reg.val) : (DW + 1)'(cfg.momentum);
        lg_c   = m_mom ? (DW + 1)'(lr_im_reg.val) : lr_c;
        mb     = wou_pkg::mulq((DW + 1)'(s.w), (DW + 1)'(cfg.shrink));
        mg2    = wou_pkg::mulq((DW + 1)'(s.g), (DW + 1)'(s.g));
        mar    = wou_pkg::mulq((DW + 1)'(cfg.rms_decay), (DW + 1)'(s.r));
        mmd    = wou_pkg::mulq(md_c, (DW + 1)'(s.d));
        mlg    = wou_pkg::mulq(lg_c, (DW + 1)'(s.g));
        s.base = cfg.l2_on ? mb.val : s.w;
        s.g2   = mg2.val;
        s.ar   = mar.val;
        s.md   = mmd.val;
        s.lg   = mlg.val;
        s.clip = (cfg.l2_on && mb.clip) || (m_sq && mg2.clip) || (m_decay && mar.clip)
               || ((m_mom || m_mr) && (mmd.clip || lr_im_reg.clip))
               || ((m_sgd || m_mom) && mlg.clip) || (m_mr && lr_m_reg.clip);
        st_next[wou_pkg::ST_MUL] = s;
    end

    // Decay of g squared, and the plain AdaGrad sum.
    always_comb
    begin
        wou_pkg::stage_t s;
        wou_pkg::sat_t   mi, a3;
        s      = st_reg[wou_pkg::ST_MUL];
        mi     = wou_pkg::mulq(ia_c, (DW + 1)'(s.g2));
        a3     = wou_pkg::add_sat(s.r, s.g2);
        s.iag2 = mi.val;
        s.r3   = a3.val;
        s.clip = s.clip || (m_decay && mi.clip) || (m_ada && a3.clip);
        st_next[wou_pkg::ST_IAG] = s;
    end

    // New accumulator and the square-root radicand.
    always_comb
    begin
        wou_pkg::stage_t s;
        wou_pkg::sat_t   sm;
        logic signed [DW:0] rad;
        s      = st_reg[wou_pkg::ST_IAG];
        sm     = wou_pkg::add_sat(s.ar, s.iag2);
        s.clip = s.clip || (m_decay && sm.clip);
        if (m_ada)
        begin
            s.rn = s.r3;
        end
        else if (m_decay)
        begin
            s.rn = sm.val;
        end
        else
        begin
            s.rn = s.r;
        end
        rad = (DW + 1)'(s.rn) + (DW + 1)'(1);
        if (rad < (DW + 1)'(1))
        begin
            rad = (DW + 1)'(1);
        end
        s.x    = {rad[DW-1:0], {wou_pkg::FRAC_BITS{1'b0}}};
        s.srem = '0;
        s.root = '0;
        st_next[wou_pkg::ST_RAD] = s;
    end

    // Square root, two radicand bits per stage.
    for (genvar i = 0; i < RW; i++)
    begin : g_sqrt
        always_comb
        begin
            wou_pkg::stage_t s;
            logic [wou_pkg::SREM_W-1:0] rem2;
            logic [wou_pkg::SREM_W-1:0] trial;
            s     = st_reg[wou_pkg::ST_SQ0 + i - 1];
            rem2  = {s.srem[wou_pkg::SREM_W-3:0], s.x[wou_pkg::X_W-1-2*i -: 2]};
            trial = {2'b00, s.root, 2'b01};
            if (rem2 >= trial)
            begin
                s.srem = rem2 - trial;
                s.root = {s.root[RW-2:0], 1'b1};
            end
            else
            begin
                s.srem = rem2;
                s.root = {s.root[RW-2:0], 1'b0};
            end
            st_next[wou_pkg::ST_SQ0 + i] = s;
        end
    end

    // Rounded numerator and quotient range check.
    always_comb
    begin
        wou_pkg::stage_t s;
        logic [DW-1:0] gmag;
        logic [NW-1:0] num;
        logic [NW-QW-1:0] hi;
        s      = st_reg[wou_pkg::ST_DPREP - 1];
        gmag   = s.g[DW-1] ? DW'(-s.g) : DW'(s.g);
        num    = {1'b0, gmag, {wou_pkg::FRAC_BITS{1'b0}}} + NW'(s.root >> 1);
        hi     = num[NW-1:QW];
        s.ovf  = (64'(hi) >= 64'(s.root));
        s.drem = s.ovf ? '0 : RW'(hi);
        s.nlo  = num[QW-1:0];
        s.q    = '0;
        st_next[wou_pkg::ST_DPREP] = s;
    end

    // Restoring division, one quotient bit per stage.
    for (genvar i = 0; i < QW; i++)
    begin : g_div
        always_comb
        begin
            wou_pkg::stage_t s;
            logic [RW:0] rem2;
            s    = st_reg[wou_pkg::ST_DV0 + i - 1];
            rem2 = {s.drem, s.nlo[QW-1-i]};
            if (rem2 >= {1'b0, s.root})
            begin
                s.drem         = RW'(rem2 - {1'b0, s.root});
                s.q[QW-1-i]    = 1'b1;
            end
            else
            begin
                s.drem = RW'(rem2);
            end
            st_next[wou_pkg::ST_DV0 + i] = s;
        end
    end

    // Signed, saturated normalized gradient.
    always_comb
    begin
        wou_pkg::stage_t s;
        logic neg, cl;
        s   = st_reg[wou_pkg::ST_GN - 1];
        neg = s.g[DW-1];
        cl  = 1'b0;
        if (s.ovf || (!neg && s.q > QW'(wou_pkg::SAT_MAX)))
        begin
            cl   = 1'b1;
            s.gn = neg ? wou_pkg::SAT_MIN : wou_pkg::SAT_MAX;
        end
        else if (neg && s.q > (QW'(1) << (QW - 1)))
        begin
            cl   = 1'b1;
            s.gn = wou_pkg::SAT_MIN;
        end
        else
        begin
            s.gn = neg ? -s.q : s.q;
        end
        s.clip = s.clip || (m_sq && cl);
        st_next[wou_pkg::ST_GN] = s;
    end

    // Learning-rate step on the normalized gradient.
    always_comb
    begin
        wou_pkg::stage_t s;
        wou_pkg::sat_t   mt;
        logic signed [DW:0] c2;
        s      = st_reg[wou_pkg::ST_GN];
        c2     = m_mr ? (DW + 1)'(lr_im_reg.val) : lr_c;
        mt     = wou_pkg::mulq(c2, (DW + 1)'(s.gn));
        s.t    = mt.val;
        s.clip = s.clip || (m_sq && mt.clip);
        st_next[wou_pkg::ST_T] = s;
    end

    // New delta and the step to add.
    always_comb
    begin
        wou_pkg::stage_t s;
        wou_pkg::sat_t   sd;
        s    = st_reg[wou_pkg::ST_T];
        sd   = '0;
        s.dn = s.d;
        s.step = '0;
        unique case (cfg.mode)
            wou_pkg::MODE_SGD:
            begin
                s.step = s.lg;
            end
            wou_pkg::MODE_MOM:
            begin
                sd     = wou_pkg::add_sat(s.lg, s.md);
                s.dn   = sd.val;
                s.step = sd.val;
            end
            wou_pkg::MODE_RMS:
            begin
                sd     = wou_pkg::add_sat(s.d, s.t);
                s.dn   = sd.val;
                s.step = sd.val;
            end
            wou_pkg::MODE_ADA:
            begin
                s.step = s.t;
            end
            wou_pkg::MODE_MR:
            begin
                sd     = wou_pkg::add_sat(s.md, s.t);
                s.dn   = sd.val;
                s.step = sd.val;
            end
            default:
            begin
                s.step = '0;
            end
        endcase
        s.clip = s.clip || sd.clip;
        st_next[wou_pkg::ST_DN] = s;
    end

    // New weight and write-back decision.
    always_comb
    begin
        wou_pkg::stage_t s;
        wou_pkg::sat_t   sw;
        s  = st_reg[wou_pkg::ST_DN];
        sw = wou_pkg::add_sat(s.base, s.step);
        if (!s.apply)
        begin
            s.wn    = s.g;
            s.dn    = '0;
            s.rn    = '0;
            s.clip  = 1'b0;
            s.write = 1'b1;
        end
        else if (!m_known)
        begin
            s.wn    = s.w;
            s.clip  = 1'b0;
            s.write = 1'b0;
        end
        else
        begin
            s.wn    = sw.val;
            s.clip  = s.clip || sw.clip;
            s.write = 1'b1;
        end
        st_next[wou_pkg::ST_WN] = s;
    end

    // Pipeline registers; only the valid flags take reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                st_reg[k].valid <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= st_reg[NSTG-1].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_index_reg <= st_reg[NSTG-1].index;
            weight_reg    <= st_reg[NSTG-1].wn;
            saturated_reg <= st_reg[NSTG-1].clip;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign weight    = weight_reg;
    assign saturated = saturated_reg;

endmodule

/* src/weight_optimizer_update_core.sv */
// Throughput: one item per cycle while the output is not stalled; the back pipeline has 69 stages,
// most in the square root (one stage per root bit) and the divider (one stage per quotient bit).
// An item whose element is still in that pipeline waits until the earlier item writes back.
// Reset clears the queue, the pipeline valid flags and the registers to their reset values;
// the element store is not cleared and must be loaded before it is used.
module weight_optimizer_update_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              operation,
    input  logic [wou_pkg::INDEX_W-1:0]       index,
    input  logic signed [wou_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [wou_pkg::INDEX_W-1:0]       out_index,
    output logic signed [wou_pkg::DATA_W-1:0] weight,
    output logic                              saturated,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wou_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wou_pkg::COEF_W-1:0]        cfg_data
);

    wou_pkg::cfg_t    cfg_reg;
    logic             q_valid;
    wou_pkg::q_item_t q_item;
    logic             q_pop;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode       <= wou_pkg::MODE_SGD;
            cfg_reg.l2_on      <= 1'b0;
            cfg_reg.learn_rate <= wou_pkg::LR_RESET;
            cfg_reg.momentum   <= wou_pkg::MOMENT_RESET;
            cfg_reg.rms_decay  <= wou_pkg::DECAY_RESET;
            cfg_reg.shrink     <= wou_pkg::SHRINK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                wou_pkg::CFG_MODE:   cfg_reg.mode       <= cfg_data[wou_pkg::MODE_W-1:0];
                wou_pkg::CFG_L2:     cfg_reg.l2_on      <= cfg_data[0];
                wou_pkg::CFG_LR:     cfg_reg.learn_rate <= cfg_data;
                wou_pkg::CFG_MOMENT: cfg_reg.momentum   <= cfg_data;
                wou_pkg::CFG_DECAY:  cfg_reg.rms_decay  <= cfg_data;
                wou_pkg::CFG_SHRINK: cfg_reg.shrink     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    wou_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .index     (index),
        .value     (value),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    wou_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_index (out_index),
        .weight    (weight),
        .saturated (saturated)
    );

endmodule

/* src/wou_checker.sv */
`include "weight_optimizer_update_core_defines.svh"

module wou_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              operation,
    input logic [wou_pkg::INDEX_W-1:0]       index,
    input logic signed [wou_pkg::DATA_W-1:0] value,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [wou_pkg::INDEX_W-1:0]       out_index,
    input logic signed [wou_pkg::DATA_W-1:0] weight,
    input logic                              saturated,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic [wou_pkg::CFG_IDX_W-1:0]     cfg_index,
    input logic [wou_pkg::COEF_W-1:0]        cfg_data
);

    // A stalled result holds until its transfer.
    `WOU_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_index) && $stable(weight) && $stable(saturated), "stalled result changed")

    // The queue fills only through an input transfer.
    `WOU_ASSERT(a_stall_rise, $rose(in_stall) |-> $past(in_valid && !in_stall), "input stall rose without a transfer")

    // Configuration writes are always taken.
    `WOU_ASSERT(a_cfg_ready, cfg_valid |-> cfg_ready, "configuration write refused")

    // No result is offered while reset is held.
    `WOU_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid, "result offered during reset")

endmodule

bind weight_optimizer_update_core wou_checker u_wou_checker (.*);

/* tb/weight_optimizer_update_core_tb.sv */
`timescale 1ns / 1ps

module weight_optimizer_update_core_tb;
    import wou_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int DRAIN_CYCLES    = 150;
    localparam int POOL_SIZE       = 8;

    typedef struct {
        logic [INDEX_W-1:0]       idx;
        logic signed [DATA_W-1:0] w;
        logic                     sat;
    } update_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic                       operation;
    logic [INDEX_W-1:0]         index;
    logic signed [DATA_W-1:0]   value;
    logic                       out_valid;
    logic                       out_stall;
    logic [INDEX_W-1:0]         out_index;
    logic signed [DATA_W-1:0]   weight;
    logic                       saturated;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [COEF_W-1:0]          cfg_data;

    // Predictor state: element stores and a copy of the registers.
    logic signed [DATA_W-1:0] weight_ref [WEIGHT_COUNT];
    logic signed [DATA_W-1:0] delta_ref  [WEIGHT_COUNT];
    logic signed [DATA_W-1:0] square_ref [WEIGHT_COUNT];
    logic [MODE_W-1:0]        cur_mode;
    logic                     cur_l2;
    logic [COEF_W-1:0]        cur_lr;
    logic [COEF_W-1:0]        cur_moment;
    logic [COEF_W-1:0]        cur_decay;
    logic [COEF_W-1:0]        cur_shrink;
    bit                       step_clip;

    update_result_t           pending_results[$];
    int                       mismatches;
    int                       cycle_count;
    int                       hold_cycles;
    bit                       no_idle;
    logic [INDEX_W-1:0]       pool [POOL_SIZE];

    weight_optimizer_update_core DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .index(index), .value(value),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_index(out_index), .weight(weight), .saturated(saturated),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Saturate to 32-bit signed and note any clipping.
    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            step_clip = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            step_clip = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Fixed-point product, rounded half away from zero.
    function automatic longint fx_mul(input longint a, input longint b);
        longint p;
        longint unsigned u;
        p = a * b;
        u = (p < 0) ? longint'(-p) : longint'(p);
        u = (u + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return clamp32((p < 0) ? -longint'(u) : longint'(u));
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // Gradient divided by the root of the accumulator plus one LSB.
    function automatic longint norm_grad(input longint g, input longint r);
        longint rad;
        longint unsigned root;
        longint unsigned n;
        longint unsigned q;
        rad = r + 1;
        if (rad < 1) rad = 1;
        root = int_sqrt(longint'(rad) << FRAC_BITS);
        if (root == 0) root = 1;
        n = ((g < 0) ? longint'(-g) : longint'(g)) << FRAC_BITS;
        q = (n + root / 2) / root;
        return clamp32((g < 0) ? -longint'(q) : longint'(q));
    endfunction

    // Compute the result of one item and update the predicted stores.
    function automatic update_result_t predict_update(input logic op,
                                                      input logic [INDEX_W-1:0] idx,
                                                      input logic signed [DATA_W-1:0] val);
        update_result_t res;
        longint lr, m, a, im, ia, d, r, base, g, g2, stp, w;
        step_clip = 1'b0;
        res.idx = idx;
        if (op == OP_LOAD)
        begin
            weight_ref[idx] = val;
            delta_ref[idx] = '0;
            square_ref[idx] = '0;
            w = val;
        end
        else if (cur_mode > MODE_MR)
            w = weight_ref[idx];
        else
        begin
            lr = cur_lr;
            m = cur_moment;
            a = cur_decay;
            im = (64'sd1 << FRAC_BITS) - m;
            ia = (64'sd1 << FRAC_BITS) - a;
            d = delta_ref[idx];
            r = square_ref[idx];
            base = weight_ref[idx];
            g = val;
            if (cur_l2) base = fx_mul(base, longint'(cur_shrink));
            if (cur_mode >= MODE_RMS)
            begin
                g2 = fx_mul(g, g);
                if (cur_mode == MODE_ADA) r = clamp32(r + g2);
                else r = clamp32(fx_mul(a, r) + fx_mul(ia, g2));
            end
            case (cur_mode)
                MODE_SGD: stp = fx_mul(lr, g);
                MODE_MOM:
                begin
                    d = clamp32(fx_mul(fx_mul(lr, im), g) + fx_mul(m, d));
                    stp = d;
                end
                MODE_RMS:
                begin
                    d = clamp32(d + fx_mul(lr, norm_grad(g, r)));
                    stp = d;
                end
                MODE_ADA: stp = fx_mul(lr, norm_grad(g, r));
                default:
                begin
                    d = clamp32(fx_mul(fx_mul(lr, m), d)
                                + fx_mul(fx_mul(lr, im), norm_grad(g, r)));
                    stp = d;
                end
            endcase
            w = clamp32(base + stp);
            weight_ref[idx] = w[DATA_W-1:0];
            delta_ref[idx] = d[DATA_W-1:0];
            square_ref[idx] = r[DATA_W-1:0];
        end
        res.w = w[DATA_W-1:0];
        res.sat = step_clip;
        return res;
    endfunction

    // Send one item, with a random gap ahead of it, and predict its result.
    task automatic send_item(input logic op, input logic [INDEX_W-1:0] idx,
                             input logic signed [DATA_W-1:0] val);
        if (!no_idle && $urandom_range(0, 99) < 12)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        index <= idx;
        value <= val;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_results.push_back(predict_update(op, idx, val));
    endtask

    // Write one register; the caller drops the valid after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_idx, input logic [COEF_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= reg_idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (reg_idx)
            CFG_MODE:   cur_mode = data[MODE_W-1:0];
            CFG_L2:     cur_l2 = data[0];
            CFG_LR:     cur_lr = data;
            CFG_MOMENT: cur_moment = data;
            CFG_DECAY:  cur_decay = data;
            CFG_SHRINK: cur_shrink = data;
            default: ;
        endcase
    endtask

    // Wait for every outstanding result, with the sender quiet.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [MODE_W-1:0] md, input logic l2,
                              input logic [COEF_W-1:0] lr, input logic [COEF_W-1:0] mo,
                              input logic [COEF_W-1:0] dc, input logic [COEF_W-1:0] sh);
        wait_idle();
        write_reg(CFG_MODE, COEF_W'(md));
        write_reg(CFG_L2, COEF_W'(l2));
        write_reg(CFG_LR, lr);
        write_reg(CFG_MOMENT, mo);
        write_reg(CFG_DECAY, dc);
        write_reg(CFG_SHRINK, sh);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? SAT_MAX : SAT_MIN;
            2: return -DATA_W'($urandom_range(0, 32'h0100_0000));
            default: return DATA_W'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return COEF_W'(ONE_Q);
            default: return COEF_W'($urandom_range(0, 32'h0100_0000));
        endcase
    endfunction

    // Loads at the extremes of index and value.
    task automatic test_loads();
        send_item(OP_LOAD, '0, SAT_MAX);
        send_item(OP_LOAD, '1, SAT_MIN);
        send_item(OP_LOAD, 12'd5, 32'sh0100_0000);
        send_item(OP_LOAD, 12'd6, '0);
    endtask

    // Each mode once, with an extreme gradient into a saturating weight.
    task automatic test_modes();
        for (int md = 0; md <= 4; md++)
        begin
            set_config(MODE_W'(md), 1'b0, LR_RESET, MOMENT_RESET, DECAY_RESET, SHRINK_RESET);
            send_item(OP_APPLY, 12'd5, 32'sh0080_0000);
            send_item(OP_APPLY, 12'd5, -32'sh0100_0000);
            send_item(OP_APPLY, '0, SAT_MAX);
            send_item(OP_APPLY, '1, SAT_MIN);
        end
    endtask

    // Shrink factor applied to the base, at zero and full scale.
    task automatic test_shrink();
        set_config(MODE_SGD, 1'b1, COEF_W'(ONE_Q), '0, '0, '0);
        send_item(OP_APPLY, 12'd6, 32'sh0000_0001);
        set_config(MODE_MR, 1'b1, COEF_W'(ONE_Q), COEF_W'(ONE_Q), COEF_W'(ONE_Q),
                   COEF_W'(ONE_Q));
        send_item(OP_APPLY, 12'd5, SAT_MIN);
    endtask

    // Unused mode codes return the stored weight.
    task automatic test_unused_modes();
        for (int md = 5; md <= 7; md++)
        begin
            set_config(MODE_W'(md), 1'b0, LR_RESET, MOMENT_RESET, DECAY_RESET, SHRINK_RESET);
            send_item(OP_APPLY, 12'd5, 32'sh1234_5678);
        end
    endtask

    // Random phases, each with its own settings over a small set of elements.
    task automatic test_random(input int phases, input int per_phase);
        logic [INDEX_W-1:0] idx;
        for (int ph = 0; ph < phases; ph++)
        begin
            set_config(($urandom_range(0, 9) == 0) ? MODE_W'($urandom_range(5, 7))
                                                   : MODE_W'($urandom_range(0, 4)),
                       1'($urandom_range(0, 1)), rand_coef(), rand_coef(), rand_coef(),
                       rand_coef());
            no_idle = (ph == 1);
            for (int i = 0; i < POOL_SIZE; i++)
            begin
                pool[i] = INDEX_W'($urandom());
                send_item(OP_LOAD, pool[i], rand_value());
            end
            for (int i = 0; i < per_phase; i++)
            begin
                idx = pool[$urandom_range(0, POOL_SIZE - 1)];
                if ($urandom_range(0, 9) == 0)
                    send_item(OP_LOAD, idx, rand_value());
                else
                    send_item(OP_APPLY, idx, rand_value());
            end
            no_idle = 1'b0;
        end
    endtask

    // Receiver holds off while the sender keeps offering items.
    task automatic test_back_pressure();
        set_config(MODE_RMS, 1'b0, LR_RESET, MOMENT_RESET, DECAY_RESET, SHRINK_RESET);
        hold_cycles = HOLD_OFF_CYCLES;
        for (int i = 0; i < 40; i++)
            send_item(OP_APPLY, pool[i % POOL_SIZE], rand_value());
        wait_idle();
        for (int i = 0; i < 10; i++)
            send_item(OP_APPLY, pool[i % POOL_SIZE], rand_value());
    endtask

    // Receiver stall: random idling, long hold-offs on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= !no_idle && ($urandom_range(0, 99) < 12);
    end

    // Compare each result transfer with the oldest prediction.
    always @(posedge clk)
    begin
        update_result_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: index %0d weight %h", out_index, weight);
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (out_index !== exp_res.idx || weight !== exp_res.w
                    || saturated !== exp_res.sat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected index %0d weight %h sat %b, got %0d %h %b",
                                 exp_res.idx, exp_res.w, exp_res.sat,
                                 out_index, weight, saturated);
                end
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_LOAD;
        index = '0;
        value = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MODE;
        cfg_data = '0;
        mismatches = 0;
        cycle_count = 0;
        hold_cycles = 0;
        no_idle = 1'b0;
        cur_mode = MODE_SGD;
        cur_l2 = 1'b0;
        cur_lr = LR_RESET;
        cur_moment = MOMENT_RESET;
        cur_decay = DECAY_RESET;
        cur_shrink = SHRINK_RESET;
        for (int i = 0; i < WEIGHT_COUNT; i++)
        begin
            weight_ref[i] = '0;
            delta_ref[i] = '0;
            square_ref[i] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_loads();
        test_modes();
        test_shrink();
        test_unused_modes();
        test_random(6, 45);
        test_back_pressure();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/wou_pkg.sv
src/wou_front.sv
src/wou_back.sv
src/weight_optimizer_update_core.sv
src/wou_checker.sv
tb/weight_optimizer_update_core_tb.sv
